// ===== rtl/stss_pkg.sv =====
// ----------------------------------------------------------------------------
// stss_pkg
// Types, character codes and character-class helpers for the source token
// span scanner.
// ----------------------------------------------------------------------------
package stss_pkg;

  // Position counter width default and reported position width
  localparam int POSITION_BITS_DEF = 16;
  localparam int OUT_POS_BITS      = 16;

  // Result buffer depth (two slots per pushed character plus slack)
  localparam int BUF_DEPTH     = 4;
  localparam int BUF_PTR_BITS  = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_BITS  = $clog2(BUF_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0B;
  localparam logic [7:0] CH_FFEED     = 8'h0C;
  localparam logic [7:0] CH_CR        = 8'h0D;

  // Input item
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] next_ch;
    logic       first;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [OUT_POS_BITS-1:0] token_start;
    logic [OUT_POS_BITS-1:0] token_stop;
    logic                    is_error;
    logic                    last_of_run;
  } out_item_t;

  // Results produced by one character, handed from the core to the buffer
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
           c == CH_FFEED || c == CH_CR;
  endfunction

endpackage

// ===== rtl/stss_in_reg.sv =====
// ----------------------------------------------------------------------------
// stss_in_reg
// Input register stage: captures one character transfer and holds it until
// the scan core consumes it.
// ----------------------------------------------------------------------------
module stss_in_reg
  import stss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     take,
  output logic     stage_valid,
  output in_item_t stage_data
);

  logic     valid_r;
  in_item_t data_r;

  // Refill whenever the stage is empty or being drained this cycle
  assign in_ready    = !valid_r || take;
  assign stage_valid = valid_r;
  assign stage_data  = data_r;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== rtl/stss_core.sv =====
// ----------------------------------------------------------------------------
// stss_core
// Scan state and per-character decision logic: tracks position, previous
// character, comment and quote modes and token bounds, and produces up to
// two results per character.
// ----------------------------------------------------------------------------
module stss_core
  import stss_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  in_item_t item,
  output push_t    push
);

  localparam logic [POSITION_BITS-1:0] POS_ALL_ONES = '1;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               prev_r, prev_nxt;
  logic                     cmt_r, cmt_nxt;
  logic                     blk_r, blk_nxt;
  logic                     quo_r, quo_nxt;
  logic [POSITION_BITS-1:0] beg_r, beg_nxt;
  logic [POSITION_BITS-1:0] end_r, end_nxt;
  logic                     failed_r, failed_nxt;

  // Effective state after an optional restart
  logic [POSITION_BITS-1:0] pos_e, beg_e, end_e, pos_prev;
  logic [7:0]               prev_e, last_ch, c, nx;
  logic                     cmt_e, blk_e, quo_e, failed_e;
  logic                     was_an, now_an;
  logic [POSITION_BITS:0]   beg_plus2;

  function automatic out_item_t mk(input logic [POSITION_BITS-1:0] s,
                                   input logic [POSITION_BITS-1:0] e,
                                   input logic err);
    out_item_t r;
    r.token_start = OUT_POS_BITS'(s);
    r.token_stop  = OUT_POS_BITS'(e);
    r.is_error    = err;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Decide results and next state for the staged character
  always_comb begin
    c        = item.ch;
    nx       = item.next_ch;
    pos_e    = item.first ? '0 : pos_r;
    prev_e   = item.first ? 8'h00 : prev_r;
    cmt_e    = item.first ? 1'b0 : cmt_r;
    blk_e    = item.first ? 1'b0 : blk_r;
    quo_e    = item.first ? 1'b0 : quo_r;
    beg_e    = item.first ? '0 : beg_r;
    end_e    = item.first ? '0 : end_r;
    failed_e = item.first ? 1'b0 : failed_r;

    last_ch   = (pos_e == '0) ? c : prev_e;
    pos_prev  = pos_e - 1'b1;
    was_an    = is_alnum(last_ch);
    now_an    = is_alnum(c);
    beg_plus2 = {1'b0, beg_e} + (POSITION_BITS+1)'(2);

    pos_nxt    = pos_e;
    prev_nxt   = prev_e;
    cmt_nxt    = cmt_e;
    blk_nxt    = blk_e;
    quo_nxt    = quo_e;
    beg_nxt    = beg_e;
    end_nxt    = end_e;
    failed_nxt = failed_e;
    push.cnt   = 2'd0;
    push.r0    = mk(pos_e, pos_e, 1'b1);
    push.r1    = mk(pos_e, pos_e, 1'b0);

    if (!failed_e) begin
      if (pos_e == POS_ALL_ONES) begin
        // Overlength
        failed_nxt = 1'b1;
        push.cnt   = 2'd1;
      end else if (!quo_e && !cmt_e && c == CH_SLASH) begin
        if (nx == CH_SLASH || nx == CH_STAR) begin
          blk_nxt = (nx == CH_STAR);
          beg_nxt = pos_e;
          cmt_nxt = 1'b1;
        end else begin
          // Lone slash
          failed_nxt = 1'b1;
          push.cnt   = 2'd1;
        end
      end else if (cmt_e) begin
        if (!blk_e && c == CH_NEWLINE) begin
          end_nxt  = pos_prev;
          cmt_nxt  = 1'b0;
          push.cnt = 2'd1;
          push.r0  = mk(beg_e, pos_prev, 1'b0);
        end else if (blk_e && c == CH_SLASH && last_ch == CH_STAR) begin
          if (beg_plus2 >= {1'b0, pos_e}) begin
            // Block comment closed on its own opening star
            failed_nxt = 1'b1;
            push.cnt   = 2'd1;
          end else begin
            end_nxt  = pos_e;
            cmt_nxt  = 1'b0;
            push.cnt = 2'd1;
            push.r0  = mk(beg_e, pos_e, 1'b0);
          end
        end
      end else if (!quo_e && c == CH_QUOTE) begin
        beg_nxt = pos_e;
        quo_nxt = 1'b1;
      end else if (quo_e) begin
        if (c == CH_QUOTE && last_ch != CH_BACKSLASH) begin
          end_nxt  = pos_e;
          quo_nxt  = 1'b0;
          push.cnt = 2'd1;
          push.r0  = mk(beg_e, pos_e, 1'b0);
        end
      end else if (is_space(c)) begin
        if (pos_e > beg_e && was_an) begin
          end_nxt  = pos_prev;
          push.cnt = 2'd1;
          push.r0  = mk(beg_e, pos_prev, 1'b0);
        end
      end else if (!was_an && now_an) begin
        beg_nxt = pos_e;
      end else if (was_an && !now_an) begin
        // Identifier closed by a special character
        beg_nxt  = pos_e;
        end_nxt  = pos_e;
        push.cnt = 2'd2;
        push.r0  = mk(beg_e, pos_prev, 1'b0);
        push.r1  = mk(pos_e, pos_e, 1'b0);
      end else if (was_an && now_an) begin
        end_nxt = end_e;
      end else if (end_e >= beg_e) begin
        beg_nxt  = pos_e;
        end_nxt  = pos_e;
        push.cnt = 2'd1;
        push.r0  = mk(pos_e, pos_e, 1'b0);
      end
      prev_nxt = c;
      pos_nxt  = pos_e + 1'b1;
    end

    // Flag the final result of this character
    push.r0.last_of_run = (push.cnt == 2'd1);
    push.r1.last_of_run = 1'b1;
    if (!adv) begin
      push.cnt = 2'd0;
    end
  end

  // Advance scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      prev_r   <= 8'h00;
      cmt_r    <= 1'b0;
      blk_r    <= 1'b0;
      quo_r    <= 1'b0;
      beg_r    <= '0;
      end_r    <= '0;
      failed_r <= 1'b0;
    end else if (adv) begin
      pos_r    <= pos_nxt;
      prev_r   <= prev_nxt;
      cmt_r    <= cmt_nxt;
      blk_r    <= blk_nxt;
      quo_r    <= quo_nxt;
      beg_r    <= beg_nxt;
      end_r    <= end_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== rtl/stss_out_buf.sv =====
// ----------------------------------------------------------------------------
// stss_out_buf
// Result buffer: takes up to two results per cycle from the core and
// presents them one per transfer on the result channel.
// ----------------------------------------------------------------------------
module stss_out_buf
  import stss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push,
  output logic      can_take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  out_item_t               buf_r [BUF_DEPTH];
  logic [BUF_PTR_BITS-1:0] wr_r, rd_r;
  logic [BUF_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    pop;

  // Room for a full pair of results
  assign can_take  = cnt_r <= BUF_CNT_BITS'(BUF_DEPTH - 2);
  assign out_valid = cnt_r != '0;
  assign out_data  = buf_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign cnt_nxt   = cnt_r + BUF_CNT_BITS'(push.cnt) - BUF_CNT_BITS'(pop);

  // Write results in order
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      buf_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      buf_r[wr_r + 1'b1] <= push.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + BUF_PTR_BITS'(push.cnt);
      rd_r  <= rd_r + BUF_PTR_BITS'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/source_token_span_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_span_scanner
// Streaming scanner that reports start and stop positions of tokens.
// ----------------------------------------------------------------------------
// Takes one source character per transfer, every cycle, and reports the
// span of each identifier, special character, quoted string and comment.
// A character is registered, scanned against the held state in one pass and
// its results (none, one or two) land in a four-entry result buffer; the
// first result is offered on the result channel from that registered buffer,
// after the character has passed the input register. A character that
// yields two results occupies the result channel for two transfers, so the
// input slows only when the buffer lacks room for a pair.
// After an error result the scanner drops characters until one arrives with
// first set.
module source_token_span_scanner
  import stss_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     stage_valid;
  in_item_t stage_data;
  logic     can_take;
  logic     adv;
  push_t    push;

  // Scan the staged character when the buffer has room for a pair
  assign adv = stage_valid && can_take;

  stss_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .take        (adv),
    .stage_valid (stage_valid),
    .stage_data  (stage_data)
  );

  stss_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (stage_data),
    .push  (push)
  );

  stss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
